// ===== hw/rtl/sle_pkg.sv =====
package sle_pkg;

   // Default sizes of the list.
   localparam int DEPTH_DEF      = 64;
   localparam int ELEM_WIDTH_DEF = 8;

   // Request kinds.
   localparam logic [3:0] KIND_PUSH_BACK    = 4'd0;
   localparam logic [3:0] KIND_POP_BACK     = 4'd1;
   localparam logic [3:0] KIND_PUSH_FRONT   = 4'd2;
   localparam logic [3:0] KIND_POP_FRONT    = 4'd3;
   localparam logic [3:0] KIND_GET          = 4'd4;
   localparam logic [3:0] KIND_SET          = 4'd5;
   localparam logic [3:0] KIND_FIND         = 4'd6;
   localparam logic [3:0] KIND_INSERT       = 4'd7;
   localparam logic [3:0] KIND_ERASE        = 4'd8;
   localparam logic [3:0] KIND_REMOVE_FIRST = 4'd9;
   localparam logic [3:0] KIND_REMOVE_ALL   = 4'd10;
   localparam logic [3:0] KIND_SORT_UP      = 4'd11;
   localparam logic [3:0] KIND_SORT_DOWN    = 4'd12;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_GET_WAIT,
      S_FIND_RD,
      S_FIND_CMP,
      S_UP_RD,
      S_UP_WR,
      S_INS,
      S_DN_RD,
      S_DN_WR,
      S_RA_RD,
      S_RA_CMP,
      S_SORT_LOAD,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_END,
      S_FIN
   } state_type;

endpackage

// ===== hw/rtl/sle_ram.sv =====
module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/sequential_list_engine.sv =====
// Packed list of up to DEPTH elements held in one synchronous RAM, with a
// sequencer that walks the RAM one element at a time. One request is in
// work at a time. Push back, pop back, set and the rejected cases go
// straight to the finish state; get waits for the registered read. Shifts
// (push or pop at the front, insert, erase, remove first) read and write
// each moved element, find and remove all read each visited element, and
// a sort runs bubble passes that shrink by one element each, all set by
// the single read port of the RAM. The response sits in an output
// register; the next request is taken once the sequencer is back in idle.
module sequential_list_engine
   import sle_pkg::*;
#(
   parameter int DEPTH      = sle_pkg::DEPTH_DEF,
   parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_kind,
   input  logic [6:0]            req_position,
   input  logic [ELEM_WIDTH-1:0] req_value,
   input  logic [ELEM_WIDTH-1:0] req_fallback,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ELEM_WIDTH-1:0] rsp_read_value,
   output logic [5:0]            rsp_match_index,
   output logic                  rsp_match_found,
   output logic [1:0]            rsp_status,
   output logic [6:0]            rsp_list_length,
   output logic                  rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 7) ? CW : 7;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         keep_ff, keep_in;
   logic [CW-1:0]         lim_ff, lim_in;
   logic [XW-1:0]         pos_ff, pos_in;
   logic [3:0]            kind_ff, kind_in;
   logic [ELEM_WIDTH-1:0] val_ff, val_in;
   logic [ELEM_WIDTH-1:0] carry_ff, carry_in;
   logic [ELEM_WIDTH-1:0] res_rd_ff, res_rd_in;
   logic [AW-1:0]         res_idx_ff, res_idx_in;
   logic                  res_found_ff, res_found_in;
   logic [1:0]            res_st_ff, res_st_in;

   logic                  rsp_valid_ff;
   logic [ELEM_WIDTH-1:0] rsp_rd_ff;
   logic [5:0]            rsp_idx_ff;
   logic                  rsp_found_ff;
   logic [1:0]            rsp_st_ff;
   logic [6:0]            rsp_len_ff;
   logic                  rsp_empty_ff;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [ELEM_WIDTH-1:0] mem_wd, mem_rd;

   logic                  accept;
   logic                  load_rsp;
   logic [XW-1:0]         req_pos_x;
   logic [XW-1:0]         cnt_x;
   logic [CW-1:0]         idx_p1;
   logic [CW-1:0]         cnt_m1;
   logic                  sort_swap;

   sle_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign load_rsp  = (state_ff == S_FIN) && !(rsp_valid_ff && rsp_stall);
   assign cnt_x     = XW'(cnt_ff);
   assign idx_p1    = idx_ff + CW'(1);
   assign cnt_m1    = cnt_ff - CW'(1);

   // Front operations work at position zero.
   always_comb begin
      if (req_kind == KIND_PUSH_FRONT || req_kind == KIND_POP_FRONT) begin
         req_pos_x = '0;
      end else begin
         req_pos_x = XW'(req_position);
      end
   end

   // Bubble step compares the carried element with the next one.
   always_comb begin
      if (kind_ff == KIND_SORT_DOWN) begin
         sort_swap = (carry_ff < mem_rd);
      end else begin
         sort_swap = (carry_ff > mem_rd);
      end
   end

   // Sequencer state register and work registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff       <= idx_in;
      keep_ff      <= keep_in;
      lim_ff       <= lim_in;
      pos_ff       <= pos_in;
      kind_ff      <= kind_in;
      val_ff       <= val_in;
      carry_ff     <= carry_in;
      res_rd_ff    <= res_rd_in;
      res_idx_ff   <= res_idx_in;
      res_found_ff <= res_found_in;
      res_st_ff    <= res_st_in;
   end

   // Next state, RAM accesses and result fields.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      lim_in       = lim_ff;
      pos_in       = pos_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      carry_in     = carry_ff;
      res_rd_in    = res_rd_ff;
      res_idx_in   = res_idx_ff;
      res_found_in = res_found_ff;
      res_st_in    = res_st_ff;
      mem_we       = 1'b0;
      mem_wa       = idx_ff[AW-1:0];
      mem_wd       = mem_rd;
      mem_re       = 1'b0;
      mem_ra       = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in      = req_kind;
               pos_in       = req_pos_x;
               val_in       = req_value;
               res_rd_in    = '0;
               res_idx_in   = '0;
               res_found_in = 1'b0;
               res_st_in    = STATUS_DONE;
               state_in     = S_FIN;
               case (req_kind)
                  KIND_PUSH_BACK: begin
                     if (cnt_ff == CW'(DEPTH)) begin
                        res_st_in = STATUS_FULL;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = cnt_ff[AW-1:0];
                        mem_wd = req_value;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  KIND_POP_BACK: begin
                     if (cnt_ff == '0) begin
                        res_st_in = STATUS_RANGE;
                     end else begin
                        cnt_in = cnt_m1;
                     end
                  end
                  KIND_PUSH_FRONT, KIND_INSERT: begin
                     if (cnt_ff == CW'(DEPTH)) begin
                        res_st_in = STATUS_FULL;
                     end else if (req_pos_x > cnt_x) begin
                        res_st_in = STATUS_RANGE;
                     end else begin
                        idx_in = cnt_ff;
                        if (req_pos_x == cnt_x) begin
                           state_in = S_INS;
                        end else begin
                           state_in = S_UP_RD;
                        end
                     end
                  end
                  KIND_POP_FRONT, KIND_ERASE: begin
                     if (req_pos_x >= cnt_x) begin
                        res_st_in = STATUS_RANGE;
                     end else begin
                        idx_in = CW'(req_pos_x);
                        if (CW'(req_pos_x) < cnt_m1) begin
                           state_in = S_DN_RD;
                        end else begin
                           cnt_in = cnt_m1;
                        end
                     end
                  end
                  KIND_GET: begin
                     if (req_pos_x >= cnt_x) begin
                        res_rd_in = req_fallback;
                        res_st_in = STATUS_RANGE;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = req_pos_x[AW-1:0];
                        state_in = S_GET_WAIT;
                     end
                  end
                  KIND_SET: begin
                     if (req_pos_x >= cnt_x) begin
                        res_st_in = STATUS_RANGE;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = req_pos_x[AW-1:0];
                        mem_wd = req_value;
                     end
                  end
                  KIND_FIND, KIND_REMOVE_FIRST: begin
                     idx_in = '0;
                     if (cnt_ff == '0) begin
                        res_st_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  KIND_REMOVE_ALL: begin
                     idx_in  = '0;
                     keep_in = '0;
                     if (cnt_ff == '0) begin
                        res_st_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = S_RA_RD;
                     end
                  end
                  KIND_SORT_UP, KIND_SORT_DOWN: begin
                     if (cnt_ff >= CW'(2)) begin
                        lim_in   = cnt_m1;
                        idx_in   = '0;
                        mem_re   = 1'b1;
                        mem_ra   = '0;
                        state_in = S_SORT_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Read data of a get arrives.
         S_GET_WAIT: begin
            res_rd_in = mem_rd;
            state_in  = S_FIN;
         end

         // Linear search for the first match.
         S_FIND_RD: begin
            mem_re   = 1'b1;
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (mem_rd == val_ff) begin
               if (kind_ff == KIND_FIND) begin
                  res_idx_in   = idx_ff[AW-1:0];
                  res_found_in = 1'b1;
                  state_in     = S_FIN;
               end else if (idx_ff < cnt_m1) begin
                  state_in = S_DN_RD;
               end else begin
                  cnt_in   = cnt_m1;
                  state_in = S_FIN;
               end
            end else begin
               idx_in = idx_p1;
               if (idx_p1 < cnt_ff) begin
                  state_in = S_FIND_RD;
               end else begin
                  res_st_in = STATUS_NOT_FOUND;
                  state_in  = S_FIN;
               end
            end
         end

         // Shift up: element idx-1 moves to idx, from the back down.
         S_UP_RD: begin
            mem_re   = 1'b1;
            mem_ra   = AW'(idx_ff - CW'(1));
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[AW-1:0];
            mem_wd = mem_rd;
            idx_in = idx_ff - CW'(1);
            if (XW'(idx_ff - CW'(1)) == pos_ff) begin
               state_in = S_INS;
            end else begin
               state_in = S_UP_RD;
            end
         end
         S_INS: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff[AW-1:0];
            mem_wd   = val_ff;
            cnt_in   = cnt_ff + CW'(1);
            state_in = S_FIN;
         end

         // Shift down: element idx+1 moves to idx.
         S_DN_RD: begin
            mem_re   = 1'b1;
            mem_ra   = idx_p1[AW-1:0];
            state_in = S_DN_WR;
         end
         S_DN_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[AW-1:0];
            mem_wd = mem_rd;
            idx_in = idx_p1;
            if (idx_p1 < cnt_m1) begin
               state_in = S_DN_RD;
            end else begin
               cnt_in   = cnt_m1;
               state_in = S_FIN;
            end
         end

         // Compaction keeps every element that differs from the value.
         S_RA_RD: begin
            mem_re   = 1'b1;
            state_in = S_RA_CMP;
         end
         S_RA_CMP: begin
            if (mem_rd != val_ff) begin
               mem_we  = 1'b1;
               mem_wa  = keep_ff[AW-1:0];
               mem_wd  = mem_rd;
               keep_in = keep_ff + CW'(1);
            end
            idx_in = idx_p1;
            if (idx_p1 < cnt_ff) begin
               state_in = S_RA_RD;
            end else begin
               if (keep_in == cnt_ff) begin
                  res_st_in = STATUS_NOT_FOUND;
               end
               cnt_in   = keep_in;
               state_in = S_FIN;
            end
         end

         // Bubble pass: the carried element travels toward the pass end.
         S_SORT_LOAD: begin
            carry_in = mem_rd;
            state_in = S_SORT_RD;
         end
         S_SORT_RD: begin
            mem_re   = 1'b1;
            mem_ra   = idx_p1[AW-1:0];
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[AW-1:0];
            if (sort_swap) begin
               mem_wd = mem_rd;
            end else begin
               mem_wd   = carry_ff;
               carry_in = mem_rd;
            end
            idx_in = idx_p1;
            if (idx_p1 == lim_ff) begin
               state_in = S_SORT_END;
            end else begin
               state_in = S_SORT_RD;
            end
         end
         S_SORT_END: begin
            mem_we = 1'b1;
            mem_wa = lim_ff[AW-1:0];
            mem_wd = carry_ff;
            lim_in = lim_ff - CW'(1);
            idx_in = '0;
            if (lim_ff == CW'(1)) begin
               state_in = S_FIN;
            end else begin
               mem_re   = 1'b1;
               mem_ra   = '0;
               state_in = S_SORT_LOAD;
            end
         end

         // Hand the result to the output register.
         S_FIN: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register for the response beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_rd_ff    <= res_rd_ff;
         rsp_idx_ff   <= 6'(res_idx_ff);
         rsp_found_ff <= res_found_ff;
         rsp_st_ff    <= res_st_ff;
         rsp_len_ff   <= 7'(cnt_ff);
         rsp_empty_ff <= (cnt_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_rd_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_list_length = rsp_len_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule
